@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL; clk and arst_n must be visible at the use site.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Expression that must never hold outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_AT(lbl, !(expr), msg)

`endif

@@ rtl/core/qrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

	localparam int OUT_W = 48;

	localparam logic [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_REAL    = 2'd0,
		KIND_COMPLEX = 2'd1,
		KIND_ZERO_A  = 2'd2
	} root_kind_t;

	typedef struct packed {
		logic cplx;
		logic a_zero;
	} disc_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Quadratic root solver. Takes a*x^2 + b*x + c and returns both real roots, or the real part
// and imaginary part of a complex pair, as signed Q32.16 values that saturate at 48 bits; a
// leading coefficient of zero is flagged with zero results. Fully pipelined: one coefficient
// triple per clock while in_stall is low. The pipeline is made up of two discriminant stages,
// one stage per square-root bit (COEF_WIDTH+FRAC_BITS+1), one numerator stage, one stage
// per quotient bit (COEF_WIDTH+FRAC_BITS+2) and the output register. A two-entry output
// buffer lets the pipeline keep advancing after out_stall rises until the skid entry fills;
// in_stall is a register output.
module quadratic_root_solver #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  signed [COEF_WIDTH-1:0]        coef_a,
	input  wire  signed [COEF_WIDTH-1:0]        coef_b,
	input  wire  signed [COEF_WIDTH-1:0]        coef_c,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output qrs_pkg::root_kind_t                 root_kind,
	output logic signed [qrs_pkg::OUT_W-1:0]    first_value,
	output logic signed [qrs_pkg::OUT_W-1:0]    second_value,
	output logic                                saturated
);
	import qrs_pkg::*;

	localparam int W      = COEF_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int MW     = 2*W + 1;
	localparam int RW     = (MW + 2*F + 1) / 2;
	localparam int QB     = W + F + 2;
	localparam int DB     = W + 1;
	localparam int SIDE_W = 2 + 2*W;
	localparam int DSW    = 4;
	localparam int EW     = ((QB > OUT_W) ? QB : OUT_W) + 1;

	logic en;

	// discriminant
	logic                d_valid;
	logic [MW-1:0]       d_mag;
	disc_flags_t         d_flags;
	logic signed [W-1:0] d_a;
	logic signed [W-1:0] d_b;

	// square root
	logic                sq_valid;
	logic [RW-1:0]       sq_root;
	logic [SIDE_W-1:0]   sq_side;
	disc_flags_t         sf;
	logic signed [W-1:0] sa;
	logic signed [W-1:0] sb;

	// numerators
	logic signed [QB:0]  bterm;
	logic signed [QB:0]  sroot;
	logic signed [QB:0]  n0;
	logic signed [QB:0]  n1;
	logic signed [DB-1:0] a_ext;

	logic                  vld_s3;
	logic [1:0][QB-1:0]    num_s3;
	logic [DB-1:0]         den_s3;
	logic [1:0]            neg_s3;
	disc_flags_t           flags_s3;

	// divider
	logic                dv_valid;
	logic [1:0][QB-1:0]  dv_quo;
	logic [DSW-1:0]      dv_side;
	disc_flags_t         df;
	logic [1:0]          dneg;

	// result forming
	logic [1:0][OUT_W-1:0] res_val;
	logic [1:0]            res_sat;
	root_kind_t            res_kind;

	// output register and skid entry
	logic              out_valid_q;
	root_kind_t        out_kind_q;
	logic [OUT_W-1:0]  out_first_q;
	logic [OUT_W-1:0]  out_second_q;
	logic              out_sat_q;
	logic              skid_full_q;
	root_kind_t        skid_kind_q;
	logic [OUT_W-1:0]  skid_first_q;
	logic [OUT_W-1:0]  skid_second_q;
	logic              skid_sat_q;

	logic out_xfer;

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;
	assign out_xfer = out_valid_q && !out_stall;

	qrs_disc #(
		.COEF_WIDTH(W)
	) u_disc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (in_valid),
		.a        (coef_a),
		.b        (coef_b),
		.c        (coef_c),
		.valid_out(d_valid),
		.mag      (d_mag),
		.flags    (d_flags),
		.a_out    (d_a),
		.b_out    (d_b)
	);

	qrs_sqrt #(
		.IN_W  (MW),
		.SHIFT (2*F),
		.SIDE_W(SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (d_valid),
		.rad_in   (d_mag),
		.side_in  ({d_flags, d_a, d_b}),
		.valid_out(sq_valid),
		.root     (sq_root),
		.side_out (sq_side)
	);

	assign {sf, sa, sb} = sq_side;

	assign bterm = -(((QB+1)'(sb)) <<< F);
	assign sroot = signed'((QB+1)'(sq_root));
	assign n0    = sf.cplx ? bterm : bterm + sroot;
	assign n1    = sf.cplx ? sroot : bterm - sroot;
	assign a_ext = (DB)'(sa);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_valid;
		end
	end

	// divide magnitudes; quotient sign is restored after the divider
	always_ff @(posedge clk) begin
		if (en) begin
			num_s3[0] <= QB'(n0[QB] ? -n0 : n0);
			num_s3[1] <= QB'(n1[QB] ? -n1 : n1);
			den_s3    <= DB'(sa[W-1] ? -a_ext : a_ext) << 1;
			neg_s3[0] <= n0[QB] ^ sa[W-1];
			neg_s3[1] <= n1[QB] ^ sa[W-1];
			flags_s3  <= sf;
		end
	end

	qrs_div #(
		.NUM_W (QB),
		.DEN_W (DB),
		.SIDE_W(DSW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (vld_s3),
		.num_in   (num_s3),
		.den_in   (den_s3),
		.side_in  ({flags_s3, neg_s3}),
		.valid_out(dv_valid),
		.quo_out  (dv_quo),
		.side_out (dv_side)
	);

	assign {df, dneg} = dv_side;

	always_comb begin
		logic [EW-1:0] mag_ext;
		logic          over;
		for (int l = 0; l < 2; l++) begin
			mag_ext = EW'(dv_quo[l]);
			if (dneg[l]) begin
				over       = (mag_ext > EW'(SAT_LO));
				res_val[l] = over ? SAT_LO : OUT_W'(-mag_ext);
			end else begin
				over       = (mag_ext > EW'(SAT_HI));
				res_val[l] = over ? SAT_HI : OUT_W'(mag_ext);
			end
			res_sat[l] = over;
			if (df.a_zero) begin
				res_val[l] = '0;
				res_sat[l] = 1'b0;
			end
		end
		if (df.a_zero) begin
			res_kind = KIND_ZERO_A;
		end else if (df.cplx) begin
			res_kind = KIND_COMPLEX;
		end else begin
			res_kind = KIND_REAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (out_xfer) begin
			if (skid_full_q) begin
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= dv_valid;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= dv_valid;
		end else if (en && dv_valid) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if ((out_xfer || !out_valid_q) && !skid_full_q) begin
			out_kind_q   <= res_kind;
			out_first_q  <= res_val[0];
			out_second_q <= res_val[1];
			out_sat_q    <= |res_sat;
		end else if (out_xfer) begin
			out_kind_q   <= skid_kind_q;
			out_first_q  <= skid_first_q;
			out_second_q <= skid_second_q;
			out_sat_q    <= skid_sat_q;
		end
		if (!out_xfer && out_valid_q && !skid_full_q) begin
			skid_kind_q   <= res_kind;
			skid_first_q  <= res_val[0];
			skid_second_q <= res_val[1];
			skid_sat_q    <= |res_sat;
		end
	end

	assign out_valid    = out_valid_q;
	assign root_kind    = out_kind_q;
	assign first_value  = signed'(out_first_q);
	assign second_value = signed'(out_second_q);
	assign saturated    = out_sat_q;

	`include "assert_macros.svh"

	`ASSERT_NEVER(a_skid_without_out, skid_full_q && !out_valid_q, "skid entry held with empty output")
	`ASSERT_AT(a_skid_fill_on_stall, $rose(skid_full_q) |-> $past(out_valid_q && out_stall), "skid filled without a stalled output")
	`ASSERT_AT(a_zero_a_result, (out_valid && root_kind == KIND_ZERO_A) |-> (first_value == '0 && second_value == '0 && !saturated), "zero leading coefficient gave nonzero result")

endmodule

`default_nettype wire

@@ rtl/core/qrs_disc.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Discriminant: products in the first stage, b*b - 4ac and its magnitude in the second.
module qrs_disc #(
	parameter int COEF_WIDTH = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            en,
	input  wire                            valid_in,
	input  wire signed [COEF_WIDTH-1:0]    a,
	input  wire signed [COEF_WIDTH-1:0]    b,
	input  wire signed [COEF_WIDTH-1:0]    c,
	output logic                           valid_out,
	output logic [2*COEF_WIDTH:0]          mag,
	output qrs_pkg::disc_flags_t           flags,
	output logic signed [COEF_WIDTH-1:0]   a_out,
	output logic signed [COEF_WIDTH-1:0]   b_out
);
	import qrs_pkg::*;

	localparam int PW = 2*COEF_WIDTH;
	localparam int DW = 2*COEF_WIDTH + 2;
	localparam int MW = 2*COEF_WIDTH + 1;

	logic                         valid_s1;
	logic signed [PW-1:0]         bb_s1;
	logic signed [PW-1:0]         ac_s1;
	logic signed [COEF_WIDTH-1:0] a_s1;
	logic signed [COEF_WIDTH-1:0] b_s1;

	logic                         valid_s2;
	logic [MW-1:0]                mag_s2;
	disc_flags_t                  flags_s2;
	logic signed [COEF_WIDTH-1:0] a_s2;
	logic signed [COEF_WIDTH-1:0] b_s2;

	logic signed [DW-1:0]         disc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1 <= PW'(b) * PW'(b);
			ac_s1 <= PW'(a) * PW'(c);
			a_s1  <= a;
			b_s1  <= b;
		end
	end

	assign disc = DW'(bb_s1) - (DW'(ac_s1) <<< 2);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2          <= MW'(disc[DW-1] ? -disc : disc);
			flags_s2.cplx   <= disc[DW-1];
			flags_s2.a_zero <= (a_s1 == '0);
			a_s2            <= a_s1;
			b_s2            <= b_s1;
		end
	end

	assign valid_out = valid_s2;
	assign mag       = mag_s2;
	assign flags     = flags_s2;
	assign a_out     = a_s2;
	assign b_out     = b_s2;

endmodule

`default_nettype wire

@@ rtl/core/qrs_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root of (rad_in << SHIFT), one root bit per stage.
module qrs_sqrt #(
	parameter int IN_W   = 33,
	parameter int SHIFT  = 32,
	parameter int SIDE_W = 34
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              en,
	input  wire                              valid_in,
	input  wire  [IN_W-1:0]                  rad_in,
	input  wire  [SIDE_W-1:0]                side_in,
	output logic                             valid_out,
	output logic [(IN_W+SHIFT+1)/2-1:0]      root,
	output logic [SIDE_W-1:0]                side_out
);
	localparam int RW = (IN_W + SHIFT + 1) / 2;
	localparam int NB = 2 * RW;

	logic              vld_s  [RW];
	logic [NB-1:0]     rad_s  [RW];
	logic [RW+1:0]     rem_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [SIDE_W-1:0] side_s [RW];

	for (genvar g = 0; g < RW; g++) begin : g_stage
		logic              v_cur;
		logic [NB-1:0]     rad_cur;
		logic [RW+1:0]     rem_cur;
		logic [RW-1:0]     root_cur;
		logic [SIDE_W-1:0] side_cur;
		logic [RW+3:0]     rem_t;
		logic [RW+3:0]     trial_t;
		logic              fit;

		if (g == 0) begin : g_head
			assign v_cur    = valid_in;
			assign rad_cur  = NB'(rad_in) << SHIFT;
			assign rem_cur  = '0;
			assign root_cur = '0;
			assign side_cur = side_in;
		end else begin : g_link
			assign v_cur    = vld_s[g-1];
			assign rad_cur  = rad_s[g-1];
			assign rem_cur  = rem_s[g-1];
			assign root_cur = root_s[g-1];
			assign side_cur = side_s[g-1];
		end

		// trial subtrahend is 4*root + 1
		assign rem_t   = {rem_cur, rad_cur[NB-1 -: 2]};
		assign trial_t = (RW+4)'({root_cur, 2'b01});
		assign fit     = (rem_t >= trial_t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g]  <= rad_cur << 2;
				rem_s[g]  <= fit ? (RW+2)'(rem_t - trial_t) : (RW+2)'(rem_t);
				root_s[g] <= {root_cur[RW-2:0], fit};
				side_s[g] <= side_cur;
			end
		end
	end

	assign valid_out = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign side_out  = side_s[RW-1];

endmodule

`default_nettype wire

@@ rtl/core/qrs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-lane pipelined unsigned divider sharing one divisor, one quotient bit per stage.
module qrs_div #(
	parameter int NUM_W  = 34,
	parameter int DEN_W  = 17,
	parameter int SIDE_W = 4
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          valid_in,
	input  wire  [1:0][NUM_W-1:0]        num_in,
	input  wire  [DEN_W-1:0]             den_in,
	input  wire  [SIDE_W-1:0]            side_in,
	output logic                         valid_out,
	output logic [1:0][NUM_W-1:0]        quo_out,
	output logic [SIDE_W-1:0]            side_out
);
	logic                    vld_s  [NUM_W];
	logic [DEN_W-1:0]        den_s  [NUM_W];
	logic [SIDE_W-1:0]       side_s [NUM_W];
	logic [1:0][DEN_W-1:0]   rem_s  [NUM_W];
	logic [1:0][NUM_W-1:0]   quo_s  [NUM_W];

	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		logic                  v_cur;
		logic [DEN_W-1:0]      den_cur;
		logic [SIDE_W-1:0]     side_cur;
		logic [1:0][DEN_W-1:0] rem_cur;
		logic [1:0][NUM_W-1:0] quo_cur;
		logic [1:0][DEN_W-1:0] rem_nxt;
		logic [1:0][NUM_W-1:0] quo_nxt;

		if (g == 0) begin : g_head
			assign v_cur    = valid_in;
			assign den_cur  = den_in;
			assign side_cur = side_in;
			assign rem_cur  = '0;
			assign quo_cur  = num_in;
		end else begin : g_link
			assign v_cur    = vld_s[g-1];
			assign den_cur  = den_s[g-1];
			assign side_cur = side_s[g-1];
			assign rem_cur  = rem_s[g-1];
			assign quo_cur  = quo_s[g-1];
		end

		// numerator bits shift out the top while quotient bits enter the bottom
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [DEN_W:0] rem_t;
			logic           fit;

			assign rem_t      = {rem_cur[l], quo_cur[l][NUM_W-1]};
			assign fit        = (rem_t >= {1'b0, den_cur});
			assign rem_nxt[l] = fit ? DEN_W'(rem_t - {1'b0, den_cur}) : DEN_W'(rem_t);
			assign quo_nxt[l] = {quo_cur[l][NUM_W-2:0], fit};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[g]  <= den_cur;
				side_s[g] <= side_cur;
				rem_s[g]  <= rem_nxt;
				quo_s[g]  <= quo_nxt;
			end
		end
	end

	assign valid_out = vld_s[NUM_W-1];
	assign quo_out   = quo_s[NUM_W-1];
	assign side_out  = side_s[NUM_W-1];

endmodule

`default_nettype wire
